// ===== hw/rtl/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat sender window package
// Operation codes and sequencer states shared by the window logic.
// ----------------------------------------------------------------------------
package srsw_pkg;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } state_t;

endpackage

// ===== hw/rtl/selective_repeat_sender_window_top.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat sender window
// Send, acknowledgement and timeout events against a window of stored slots.
// ----------------------------------------------------------------------------
// Send, timeout, refused and rejected transactions are registered, executed
// in ST_EXEC, and give a registered result strobe when the next one can start.
// An acknowledgement at the window base slides the base, reading then checking
// each passed slot (ST_SCAN_RD, ST_SCAN_CHK) up to the next sequence number or
// an unacknowledged slot. Results cannot be stalled. Synchronous reset clears
// the pointers, the full flag and the ack valid bits, not the payload memory.
module selective_repeat_sender_window_top
  import srsw_pkg::*;
#(
  parameter int SEQ_SPACE    = 8,
  parameter int WINDOW       = 4,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_seq_number,
  input  logic        in_ack_intact,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  output logic        out_accepted,
  output logic        out_transmit,
  output logic [2:0]  out_packet_seq,
  output logic [31:0] out_packet_payload,
  output logic        out_timer_start,
  output logic        out_timer_stop,
  output logic [2:0]  out_window_base,
  output logic [2:0]  out_next_sequence,
  output logic        out_window_full
);

  localparam int SW    = $clog2(SEQ_SPACE);
  localparam int SXW   = (SW > 3) ? SW : 3;
  localparam int EFFW  = (WINDOW < SEQ_SPACE) ? WINDOW : (SEQ_SPACE - 1);
  localparam int PW_IN = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

  function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] v);
    return (v == SW'(SEQ_SPACE - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [SW-1:0] f_dist(input logic [SW-1:0] a,
                                           input logic [SW-1:0] b);
    logic [SW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + (SW+1)'(SEQ_SPACE);
    end
    return d[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] f_idx(input logic [2:0] s);
    logic [SXW-1:0] x;
    x = SXW'(s);
    return x[SW-1:0];
  endfunction

  function automatic logic f_ok(input logic [2:0] s);
    return ({29'd0, s} < 32'(SEQ_SPACE));
  endfunction

  function automatic logic [2:0] f_out3(input logic [SW-1:0] v);
    logic [SXW-1:0] x;
    x = SXW'(v);
    return x[2:0];
  endfunction

  state_t state_r, state_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          full_r, full_nxt;

  op_t         op_r;
  logic [2:0]  seq_r;
  logic        intact_r;
  logic [31:0] pay_r;

  logic [SEQ_SPACE-1:0] ack_vld_r;
  logic                 ack_vq_r;

  logic          ack_we, ack_wdata, ack_re, ack_rd;
  logic [SW-1:0] ack_waddr, ack_raddr;
  logic          pay_we, pay_re;
  logic [SW-1:0] pay_raddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rd, pay_src;

  logic          fin, r_acc, r_tx, r_tstart, r_tstop, r_from_mem;
  logic [SW-1:0] r_pseq;
  logic [SW-1:0] seq_idx, len;
  logic          acked_now;
  logic [31:0]   out_pay_nxt;

  logic        out_valid_r, out_accepted_r, out_transmit_r;
  logic [2:0]  out_packet_seq_r, out_window_base_r, out_next_sequence_r;
  logic [31:0] out_packet_payload_r;
  logic        out_timer_start_r, out_timer_stop_r, out_window_full_r;

  srsw_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SEQ_SPACE), .AW(SW)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (next_r),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rd)
  );

  srsw_ram #(.WIDTH(1), .DEPTH(SEQ_SPACE), .AW(SW)) u_ack_ram (
    .clk   (clk),
    .we    (ack_we),
    .waddr (ack_waddr),
    .wdata (ack_wdata),
    .re    (ack_re),
    .raddr (ack_raddr),
    .rdata (ack_rd)
  );

  assign seq_idx   = f_idx(seq_r);
  assign len       = f_dist(next_r, base_r);
  assign acked_now = ack_vq_r & ack_rd;
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    pay_wdata = '0;
    pay_wdata[PW_IN-1:0] = pay_r[PW_IN-1:0];
    pay_src = r_from_mem ? pay_rd : pay_wdata;
    out_pay_nxt = '0;
    if (r_tx) begin
      out_pay_nxt[PW_IN-1:0] = pay_src[PW_IN-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    ack_we     = 1'b0;
    ack_waddr  = seq_idx;
    ack_wdata  = 1'b0;
    ack_re     = 1'b0;
    ack_raddr  = f_idx(in_seq_number);
    pay_we     = 1'b0;
    pay_re     = 1'b0;
    pay_raddr  = f_idx(in_seq_number);
    fin        = 1'b0;
    r_acc      = 1'b0;
    r_tx       = 1'b0;
    r_tstart   = 1'b0;
    r_tstop    = 1'b0;
    r_from_mem = 1'b0;
    r_pseq     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ack_re    = 1'b1;
          pay_re    = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_r)
          OP_SEND: begin
            fin = 1'b1;
            state_nxt = ST_IDLE;
            if (!full_r) begin
              pay_we    = 1'b1;
              ack_we    = 1'b1;
              ack_waddr = next_r;
              ack_wdata = 1'b0;
              next_nxt  = f_inc(next_r);
              r_acc     = 1'b1;
              r_tx      = 1'b1;
              r_tstart  = 1'b1;
              r_pseq    = next_r;
            end
          end
          OP_ACK: begin
            fin = 1'b1;
            state_nxt = ST_IDLE;
            if (intact_r && f_ok(seq_r) && !acked_now &&
                (f_dist(seq_idx, base_r) < SW'(EFFW))) begin
              r_acc     = 1'b1;
              r_tstop   = 1'b1;
              r_pseq    = seq_idx;
              ack_we    = 1'b1;
              ack_waddr = seq_idx;
              ack_wdata = (seq_idx != base_r);
              if (seq_idx == base_r) begin
                fin       = 1'b0;
                state_nxt = ST_SCAN_RD;
                cur_nxt   = f_inc(base_r);
                cnt_nxt   = (len == '0) ? '0 : len - 1'b1;
              end
            end
          end
          OP_TIMEOUT: begin
            fin = 1'b1;
            state_nxt = ST_IDLE;
            if (f_ok(seq_r)) begin
              r_acc      = 1'b1;
              r_tx       = 1'b1;
              r_tstart   = 1'b1;
              r_from_mem = 1'b1;
              r_pseq     = seq_idx;
            end
          end
          default: begin
            fin = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN_RD: begin
        if (cnt_r == '0) begin
          base_nxt  = next_r;
          fin       = 1'b1;
          r_acc     = 1'b1;
          r_tstop   = 1'b1;
          r_pseq    = seq_idx;
          state_nxt = ST_IDLE;
        end else begin
          ack_re    = 1'b1;
          ack_raddr = cur_r;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (!acked_now) begin
          base_nxt  = cur_r;
          fin       = 1'b1;
          r_acc     = 1'b1;
          r_tstop   = 1'b1;
          r_pseq    = seq_idx;
          state_nxt = ST_IDLE;
        end else begin
          ack_we    = 1'b1;
          ack_waddr = cur_r;
          ack_wdata = 1'b0;
          cur_nxt   = f_inc(cur_r);
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    full_nxt = (f_dist(next_nxt, base_nxt) == SW'(EFFW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      full_r      <= 1'b0;
      cur_r       <= '0;
      cnt_r       <= '0;
      ack_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= fin;
      if (fin) begin
        full_r <= full_nxt;
      end
      if (ack_we) begin
        ack_vld_r[ack_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= op_t'(in_operation);
      seq_r    <= in_seq_number;
      intact_r <= in_ack_intact;
      pay_r    <= in_payload;
    end
    if (ack_re) begin
      ack_vq_r <= ack_vld_r[ack_raddr];
    end
    if (fin) begin
      out_accepted_r       <= r_acc;
      out_transmit_r       <= r_tx;
      out_packet_seq_r     <= f_out3(r_pseq);
      out_packet_payload_r <= out_pay_nxt;
      out_timer_start_r    <= r_tstart;
      out_timer_stop_r     <= r_tstop;
      out_window_base_r    <= f_out3(base_nxt);
      out_next_sequence_r  <= f_out3(next_nxt);
      out_window_full_r    <= full_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_transmit       = out_transmit_r;
  assign out_packet_seq     = out_packet_seq_r;
  assign out_packet_payload = out_packet_payload_r;
  assign out_timer_start    = out_timer_start_r;
  assign out_timer_stop     = out_timer_stop_r;
  assign out_window_base    = out_window_base_r;
  assign out_next_sequence  = out_next_sequence_r;
  assign out_window_full    = out_window_full_r;

  // The full flag always agrees with the distance between the pointers.
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    full_r == (f_dist(next_r, base_r) == SW'(EFFW)))
    else $error("full flag disagrees with window length");

  // Every result follows a cycle in which the sequencer was working.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // A transmitted packet is always an accepted transaction that starts a timer.
  a_tx_implies_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_transmit) |-> (out_accepted && out_timer_start && !out_timer_stop))
    else $error("transmit without accepted timer start");

  // The base slide never runs past the number of outstanding slots.
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CHK) |-> (cnt_r != '0))
    else $error("base slide scanned beyond the outstanding slots");

endmodule

// ===== hw/rtl/srsw_ram.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat sender window RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module srsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
